/* hdl/assert_macros.svh */
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Expression holds at every clock edge out of reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hdl/esa_pkg.sv */
package esa_pkg;

	localparam int FIELD_W  = 11;
	localparam int STATUS_W = 2;

	localparam logic OP_CREATE  = 1'b0;
	localparam logic OP_DESTROY = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_LIVE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_CR_POP,
		S_CR_POPW,
		S_CR_FRESH,
		S_CR_INC,
		S_CR_APPEND,
		S_DS_CHK,
		S_DS_MAP,
		S_DS_LAST,
		S_DS_CLR,
		S_OUT
	} state_t;

endpackage

/* hdl/esa_ram.sv */
module esa_ram #(
	parameter int DW     = 11,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              en,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DW-1:0]     wdata,
	output logic [DW-1:0]     rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/esa_alu.sv */
module esa_alu #(
	parameter int W = 11
) (
	input  logic             [W-1:0] a,
	input  logic             [W-1:0] b,
	input  esa_pkg::alu_op_t         op,
	output logic             [W-1:0] res,
	output logic                     carry
);

	import esa_pkg::*;

	logic [W:0]   sum;
	logic [W-1:0] b_eff;
	logic         sub;

	// Subtract as a + ~b + 1; carry out set means a >= b.
	always_comb begin
		sub   = (op == ALU_SUB);
		b_eff = sub ? ~b : b;
		sum   = {1'b0, a} + {1'b0, b_eff} + {{W{1'b0}}, sub};
	end

	assign res   = sum[W-1:0];
	assign carry = sum[W];

endmodule

/* hdl/entity_id_sparse_set_allocator_top.sv */
// Requests are taken one at a time: in_ready is high only in S_IDLE, entered again
// when S_OUT moves the result out (it waits while out_valid is high and out_ready
// low). Create reuses a freed id, else takes a fresh id, else reports full. The pace
// is set by the single shared adder and the registered reads of the single-port free
// stack, dense list and sparse map memories. Reset: arst_n clears counters and control;
// a clearing pass then marks all MAX_IDS+1 sparse map entries invalid, with in_ready low.
`include "assert_macros.svh"

module entity_id_sparse_set_allocator_top #(
	parameter int MAX_IDS = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           op,
	input  logic [esa_pkg::FIELD_W-1:0]    target_id,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [esa_pkg::FIELD_W-1:0]    result_id,
	output logic [esa_pkg::FIELD_W-1:0]    slot_info,
	output logic [esa_pkg::STATUS_W-1:0]   status
);

	import esa_pkg::*;

	localparam int CNT_W = $clog2(MAX_IDS + 1);
	localparam int IDX_W = $clog2(MAX_IDS);
	localparam int SP_DW = IDX_W + 1;
	localparam int AW    = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;

	localparam logic [AW-1:0]    MAX_A = AW'(MAX_IDS);
	localparam logic [AW-1:0]    ONE_A = AW'(1);
	localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_IDS);

	state_t state_q, state_d;

	logic [FIELD_W-1:0]  tid_q;
	logic [CNT_W-1:0]    free_count_q, next_fresh_q, live_count_q, clr_q;
	logic [CNT_W-1:0]    id_q;
	logic [IDX_W-1:0]    idx_q;
	logic [FIELD_W-1:0]  res_id_q, res_slot_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                out_valid_q;
	logic [FIELD_W-1:0]  out_id_q, out_slot_q;
	logic [STATUS_W-1:0] out_status_q;

	logic [AW-1:0] alu_a, alu_b, alu_res;
	alu_op_t       alu_op;
	logic          alu_carry;

	logic             fs_en, fs_we;
	logic [IDX_W-1:0] fs_addr;
	logic [CNT_W-1:0] fs_wdata, fs_rdata;
	logic             dn_en, dn_we;
	logic [IDX_W-1:0] dn_addr;
	logic [CNT_W-1:0] dn_wdata, dn_rdata;
	logic             sp_en, sp_we;
	logic [CNT_W-1:0] sp_addr;
	logic [SP_DW-1:0] sp_wdata, sp_rdata;

	logic [AW-1:0] tid_a, id_a, lc_a, idx_a;
	logic          accept, out_move;

	assign tid_a = AW'(tid_q);
	assign id_a  = AW'(id_q);
	assign lc_a  = AW'(live_count_q);
	assign idx_a = AW'(idx_q);

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_move = (state_q == S_OUT) && (!out_valid_q || out_ready);

	esa_alu #(.W(AW)) u_alu (
		.a     (alu_a),
		.b     (alu_b),
		.op    (alu_op),
		.res   (alu_res),
		.carry (alu_carry)
	);

	esa_ram #(.DW(CNT_W), .DEPTH(MAX_IDS), .ADDR_W(IDX_W)) u_free_stack (
		.clk   (clk),
		.en    (fs_en),
		.we    (fs_we),
		.addr  (fs_addr),
		.wdata (fs_wdata),
		.rdata (fs_rdata)
	);

	esa_ram #(.DW(CNT_W), .DEPTH(MAX_IDS), .ADDR_W(IDX_W)) u_dense_list (
		.clk   (clk),
		.en    (dn_en),
		.we    (dn_we),
		.addr  (dn_addr),
		.wdata (dn_wdata),
		.rdata (dn_rdata)
	);

	esa_ram #(.DW(SP_DW), .DEPTH(MAX_IDS + 1), .ADDR_W(CNT_W)) u_sparse_map (
		.clk   (clk),
		.en    (sp_en),
		.we    (sp_we),
		.addr  (sp_addr),
		.wdata (sp_wdata),
		.rdata (sp_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		alu_a    = '0;
		alu_b    = ONE_A;
		alu_op   = ALU_ADD;
		fs_en    = 1'b0;
		fs_we    = 1'b0;
		fs_addr  = '0;
		fs_wdata = '0;
		dn_en    = 1'b0;
		dn_we    = 1'b0;
		dn_addr  = '0;
		dn_wdata = '0;
		sp_en    = 1'b0;
		sp_we    = 1'b0;
		sp_addr  = '0;
		sp_wdata = '0;
		unique case (state_q)
			S_CLR: begin
				sp_en   = 1'b1;
				sp_we   = 1'b1;
				sp_addr = clr_q;
				alu_a   = AW'(clr_q);
				if (clr_q == MAX_C) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = (op == OP_CREATE) ? S_CR_POP : S_DS_CHK;
				end
			end
			S_CR_POP: begin
				// Pop the most recent freed id if the stack is not empty.
				alu_a  = AW'(free_count_q);
				alu_op = ALU_SUB;
				if (alu_carry) begin
					fs_en   = 1'b1;
					fs_addr = alu_res[IDX_W-1:0];
					state_d = S_CR_POPW;
				end else begin
					state_d = S_CR_FRESH;
				end
			end
			S_CR_POPW: begin
				state_d = S_CR_APPEND;
			end
			S_CR_FRESH: begin
				alu_a   = AW'(next_fresh_q);
				alu_b   = MAX_A;
				alu_op  = ALU_SUB;
				state_d = alu_carry ? S_OUT : S_CR_INC;
			end
			S_CR_INC: begin
				alu_a   = AW'(next_fresh_q);
				state_d = S_CR_APPEND;
			end
			S_CR_APPEND: begin
				dn_en    = 1'b1;
				dn_we    = 1'b1;
				dn_addr  = live_count_q[IDX_W-1:0];
				dn_wdata = id_q;
				sp_en    = 1'b1;
				sp_we    = 1'b1;
				sp_addr  = id_q;
				sp_wdata = {1'b1, live_count_q[IDX_W-1:0]};
				alu_a    = lc_a;
				state_d  = S_OUT;
			end
			S_DS_CHK: begin
				// Range check: target must be nonzero and not above MAX_IDS.
				alu_a  = MAX_A;
				alu_b  = tid_a;
				alu_op = ALU_SUB;
				if (alu_carry && (tid_q != '0)) begin
					sp_en   = 1'b1;
					sp_addr = tid_a[CNT_W-1:0];
					state_d = S_DS_MAP;
				end else begin
					state_d = S_OUT;
				end
			end
			S_DS_MAP: begin
				alu_a  = lc_a;
				alu_op = ALU_SUB;
				if (sp_rdata[SP_DW-1]) begin
					dn_en   = 1'b1;
					dn_addr = alu_res[IDX_W-1:0];
					state_d = S_DS_LAST;
				end else begin
					state_d = S_OUT;
				end
			end
			S_DS_LAST: begin
				// Move the last dense entry into the freed slot and push the id.
				dn_en    = 1'b1;
				dn_we    = 1'b1;
				dn_addr  = idx_q;
				dn_wdata = dn_rdata;
				sp_en    = 1'b1;
				sp_we    = 1'b1;
				sp_addr  = dn_rdata;
				sp_wdata = {1'b1, idx_q};
				fs_en    = 1'b1;
				fs_we    = 1'b1;
				fs_addr  = free_count_q[IDX_W-1:0];
				fs_wdata = tid_a[CNT_W-1:0];
				alu_a    = AW'(free_count_q);
				state_d  = S_DS_CLR;
			end
			S_DS_CLR: begin
				// Invalidate after the moved entry so a self move ends invalid.
				sp_en   = 1'b1;
				sp_we   = 1'b1;
				sp_addr = tid_a[CNT_W-1:0];
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_count_q <= '0;
			next_fresh_q <= '0;
			live_count_q <= '0;
			clr_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLR:       clr_q <= alu_res[CNT_W-1:0];
				S_CR_POP: begin
					if (alu_carry) begin
						free_count_q <= alu_res[CNT_W-1:0];
					end
				end
				S_CR_INC:    next_fresh_q <= alu_res[CNT_W-1:0];
				S_CR_APPEND: live_count_q <= alu_res[CNT_W-1:0];
				S_DS_MAP: begin
					if (sp_rdata[SP_DW-1]) begin
						live_count_q <= alu_res[CNT_W-1:0];
					end
				end
				S_DS_LAST:   free_count_q <= alu_res[CNT_W-1:0];
				default: begin
				end
			endcase
			if (out_move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tid_q <= target_id;
		end
		unique case (state_q)
			S_CR_POPW: id_q <= fs_rdata;
			S_CR_FRESH: begin
				if (alu_carry) begin
					res_id_q     <= '0;
					res_slot_q   <= lc_a[FIELD_W-1:0];
					res_status_q <= ST_FULL;
				end
			end
			S_CR_INC:  id_q <= alu_res[CNT_W-1:0];
			S_CR_APPEND: begin
				res_id_q     <= id_a[FIELD_W-1:0];
				res_slot_q   <= alu_res[FIELD_W-1:0];
				res_status_q <= ST_OK;
			end
			S_DS_CHK: begin
				res_id_q     <= tid_q;
				res_slot_q   <= '0;
				res_status_q <= ST_NOT_LIVE;
			end
			S_DS_MAP:  idx_q <= sp_rdata[IDX_W-1:0];
			S_DS_CLR: begin
				res_id_q     <= tid_q;
				res_slot_q   <= idx_a[FIELD_W-1:0];
				res_status_q <= ST_OK;
			end
			default: begin
			end
		endcase
		if (out_move) begin
			out_id_q     <= res_id_q;
			out_slot_q   <= res_slot_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign result_id = out_id_q;
	assign slot_info = out_slot_q;
	assign status    = out_status_q;

	`ASSERT_IMPL(a_count_balance, clk, arst_n, state_q == S_IDLE, live_count_q + free_count_q == next_fresh_q, "live plus free ids differ from ids handed out")
	`ASSERT_HOLDS(a_count_bound, clk, arst_n, (free_count_q <= MAX_C) && (next_fresh_q <= MAX_C) && (live_count_q <= MAX_C), "id counter above MAX_IDS")
	`ASSERT_IMPL(a_full_id_zero, clk, arst_n, out_valid_q && (out_status_q == ST_FULL), out_id_q == '0, "full status with nonzero id")
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, state_q != S_IDLE, "request accepted but sequencer stayed idle")

endmodule
